/* hw/rtl/mgs_pkg.sv */
// Shared types, widths, sequencer program and exp table math for the Gaussian sampler.
package mgs_pkg;

    // Field and datapath widths
    localparam int STEP_W     = 13;
    localparam int DRAW_W     = 16;
    localparam int POS_W      = 16;
    localparam int PREC_W     = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int DELTA_W    = 14;
    localparam int SUM_W      = 18;
    localparam int MUL_W      = 18;
    localparam int MUL_OUT_W  = 2 * MUL_W;
    localparam int DIFF_W     = 32;
    localparam int HALF_W     = DIFF_W / 2;
    localparam int PROD_W     = 48;
    localparam int ENTRY_W    = 17;
    localparam int SEQ_W      = 3;
    localparam int SEQ_DEPTH  = 1 << SEQ_W;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRECISION = 1'd1;

    localparam logic [POS_W-1:0]  CENTER_RESET    = 16'sd0;
    localparam logic [PREC_W-1:0] PRECISION_RESET = 16'd2048;

    // Datapath operations
    localparam logic [2:0] OP_LOAD     = 3'd0;
    localparam logic [2:0] OP_MUL_DIFF = 3'd1;
    localparam logic [2:0] OP_MUL_LO   = 3'd2;
    localparam logic [2:0] OP_MUL_HI   = 3'd3;
    localparam logic [2:0] OP_ADD_HI   = 3'd4;
    localparam logic [2:0] OP_DECIDE   = 3'd5;
    localparam logic [2:0] OP_FINISH   = 3'd6;
    localparam logic [2:0] OP_NOP      = 3'd7;

    // Jump conditions: jump to target while the condition holds
    localparam logic [1:0] COND_NEVER    = 2'd0;
    localparam logic [1:0] COND_IN_WAIT  = 2'd1;
    localparam logic [1:0] COND_OUT_BUSY = 2'd2;

    typedef struct packed {
        logic [2:0]       op;
        logic [1:0]       cond;
        logic [SEQ_W-1:0] target;
        logic             done;
    } ctrl_t;

    // One Metropolis step
    localparam ctrl_t PROGRAM [SEQ_DEPTH] = '{
        '{OP_LOAD,     COND_IN_WAIT,  3'd0, 1'b0},
        '{OP_MUL_DIFF, COND_NEVER,    3'd0, 1'b0},
        '{OP_MUL_LO,   COND_NEVER,    3'd0, 1'b0},
        '{OP_MUL_HI,   COND_NEVER,    3'd0, 1'b0},
        '{OP_ADD_HI,   COND_NEVER,    3'd0, 1'b0},
        '{OP_DECIDE,   COND_NEVER,    3'd0, 1'b0},
        '{OP_FINISH,   COND_OUT_BUSY, 3'd6, 1'b1},
        '{OP_NOP,      COND_NEVER,    3'd0, 1'b1}
    };

    // exp(-1/64) in Q1.63 from the alternating series, each term truncated
    localparam logic [63:0] Q63_ONE = 64'h8000_0000_0000_0000;
    localparam logic [63:0] EXP_T1  = Q63_ONE / 64'd64;
    localparam logic [63:0] EXP_T2  = EXP_T1 / 64'd128;
    localparam logic [63:0] EXP_T3  = EXP_T2 / 64'd192;
    localparam logic [63:0] EXP_T4  = EXP_T3 / 64'd256;
    localparam logic [63:0] EXP_T5  = EXP_T4 / 64'd320;
    localparam logic [63:0] EXP_T6  = EXP_T5 / 64'd384;
    localparam logic [63:0] EXP_T7  = EXP_T6 / 64'd448;
    localparam logic [63:0] EXP_T8  = EXP_T7 / 64'd512;
    localparam logic [63:0] EXP_T9  = EXP_T8 / 64'd576;
    localparam logic [63:0] EXP_T10 = EXP_T9 / 64'd640;
    localparam logic [63:0] EXP_T11 = EXP_T10 / 64'd704;
    localparam logic [63:0] EXP_T12 = EXP_T11 / 64'd768;
    localparam logic [63:0] EXP_T13 = EXP_T12 / 64'd832;
    localparam logic [63:0] EXP_T14 = EXP_T13 / 64'd896;
    localparam logic [63:0] EXP_T15 = EXP_T14 / 64'd960;
    localparam logic [63:0] EXP_T16 = EXP_T15 / 64'd1024;
    localparam logic [63:0] DECAY_RATIO = Q63_ONE - EXP_T1 + EXP_T2 - EXP_T3 + EXP_T4
                                          - EXP_T5 + EXP_T6 - EXP_T7 + EXP_T8 - EXP_T9
                                          + EXP_T10 - EXP_T11 + EXP_T12 - EXP_T13
                                          + EXP_T14 - EXP_T15 + EXP_T16;

    // floor(a * b / 2^63), elaboration only
    function automatic logic [63:0] mul_q63(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[126:63];
    endfunction

    // floor(65536 * exp(-idx/64)) by square and multiply
    function automatic logic [ENTRY_W-1:0] exp_entry(input int unsigned idx,
                                                     input logic [63:0] ratio);
        logic [63:0] acc;
        logic [63:0] base;
        int unsigned rem;
        acc  = 64'h8000_0000_0000_0000;
        base = ratio;
        rem  = idx;
        while (rem != 0)
        begin
            if (rem % 2 == 1)
                acc = mul_q63(acc, base);
            base = mul_q63(base, base);
            rem  = rem / 2;
        end
        return acc[63:47];
    endfunction

endpackage

/* hw/rtl/mgs_if.sv */
// Handshake channels of the Gaussian sampler: input items, results, register writes.
interface mgs_item_if import mgs_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [STEP_W-1:0] proposal_step;
    logic [DRAW_W-1:0]        uniform_draw;
    logic                     first_of_run;

    modport source (output valid, proposal_step, uniform_draw, first_of_run, input ready);
    modport sink   (input valid, proposal_step, uniform_draw, first_of_run, output ready);
endinterface

interface mgs_result_if import mgs_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] sample;
    logic                    accepted;

    modport source (output valid, sample, accepted, input ready);
    modport sink   (input valid, sample, accepted, output ready);
endinterface

interface mgs_cfg_if import mgs_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/metropolis_gaussian_sampler_unit.sv */
// Top level: microcoded random-walk Metropolis sampler for a Gaussian target.
//
//  channel  dir  fields                                     transaction
//  item     in   proposal_step, uniform_draw, first_of_run  one Metropolis step
//  result   out  sample, accepted                           one per item
//  cfg      in   index, data                                register write
//
// The control program has 7 steps (load, three passes through the shared 18x18 multiplier,
// accumulate, table lookup, finish), one per cycle while the program is not stalled.
// The next item is accepted only once the program returns to step 0, so a new item is
// not taken before the result of the last one has been loaded into the output register.
// A result waiting in the output register stalls the program at the finish step only.
// Reset clears position and the sequencer and sets the registers to their reset values; the exp table is a ROM.
module metropolis_gaussian_sampler_unit
    import mgs_pkg::*;
#(
    parameter int TABLE_DEPTH   = 1024,
    parameter int FRACTION_BITS = 12
)
(
    input  logic         clk,
    input  logic         rst_n,
    mgs_item_if.sink     item,
    mgs_result_if.source result,
    mgs_cfg_if.sink      cfg
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int SHIFT = 3 * FRACTION_BITS - 6;

    typedef logic [ENTRY_W-1:0] rom_t [TABLE_DEPTH];

    function automatic rom_t build_rom();
        rom_t        rom;
        logic [63:0] ratio;
        ratio = DECAY_RATIO;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            rom[i] = exp_entry(i, ratio);
        end
        return rom;
    endfunction

    localparam rom_t EXP_ROM = build_rom();

    // Configuration registers
    logic signed [POS_W-1:0] center_reg;
    logic [PREC_W-1:0]       precision_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg    <= CENTER_RESET;
            precision_reg <= PRECISION_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_CENTER:    center_reg    <= cfg.data;
                CFG_PRECISION: precision_reg <= cfg.data;
                default:       ;
            endcase
        end
    end

    // Sequencer
    logic [SEQ_W-1:0] step_reg;
    logic [SEQ_W-1:0] step_next;
    ctrl_t            ctrl;
    logic             stall;
    logic             run;
    logic             result_valid_reg;

    assign ctrl = PROGRAM[step_reg];

    always_comb
    begin
        unique case (ctrl.cond)
            COND_IN_WAIT:  stall = !item.valid;
            COND_OUT_BUSY: stall = result_valid_reg && !result.ready;
            default:       stall = 1'b0;
        endcase
    end

    assign run = !stall;

    always_comb
    begin
        if (stall)
            step_next = ctrl.target;
        else if (ctrl.done)
            step_next = '0;
        else
            step_next = step_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else
            step_reg <= step_next;
    end

    assign item.ready = (ctrl.op == OP_LOAD);

    // Candidate forming at load
    logic signed [POS_W-1:0]   position_reg;
    logic signed [POS_W-1:0]   base_pos;
    logic signed [POS_W:0]     cand_wide;
    logic signed [POS_W-1:0]   cand;
    logic signed [POS_W:0]     delta_wide;
    logic signed [SUM_W-1:0]   sum_wide;

    logic signed [POS_W-1:0]   base_reg;
    logic signed [POS_W-1:0]   cand_reg;
    logic signed [DELTA_W-1:0] delta_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic [DRAW_W-1:0]         draw_reg;

    assign base_pos  = item.first_of_run ? '0 : position_reg;
    assign cand_wide = (POS_W+1)'(base_pos) + (POS_W+1)'(item.proposal_step);

    always_comb
    begin
        if (cand_wide > (POS_W+1)'(signed'(16'sh7FFF)))
            cand = 16'sh7FFF;
        else if (cand_wide < (POS_W+1)'(signed'(16'sh8000)))
            cand = 16'sh8000;
        else
            cand = cand_wide[POS_W-1:0];
    end

    // d1^2 - d0^2 = (cand - pos) * (cand + pos - 2 center)
    assign delta_wide = (POS_W+1)'(cand) - (POS_W+1)'(base_pos);
    assign sum_wide   = SUM_W'(cand) + SUM_W'(base_pos) - (SUM_W'(center_reg) <<< 1);

    always_ff @(posedge clk)
    begin
        if (run && ctrl.op == OP_LOAD)
        begin
            base_reg  <= base_pos;
            cand_reg  <= cand;
            delta_reg <= delta_wide[DELTA_W-1:0];
            sum_reg   <= sum_wide;
            draw_reg  <= item.uniform_draw;
        end
    end

    // Shared multiplier
    logic signed [MUL_W-1:0]     mul_a;
    logic signed [MUL_W-1:0]     mul_b;
    logic signed [MUL_OUT_W-1:0] mul_p;
    logic signed [DIFF_W-1:0]    diff_reg;
    logic signed [MUL_OUT_W-1:0] mul_reg;
    logic signed [PROD_W-1:0]    prod_reg;

    always_comb
    begin
        case (ctrl.op)
            OP_MUL_DIFF:
            begin
                mul_a = MUL_W'(delta_reg);
                mul_b = sum_reg;
            end
            OP_MUL_LO:
            begin
                mul_a = {2'b00, precision_reg};
                mul_b = {2'b00, diff_reg[HALF_W-1:0]};
            end
            default:
            begin
                mul_a = {2'b00, precision_reg};
                mul_b = MUL_W'(signed'(diff_reg[DIFF_W-1:HALF_W]));
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge clk)
    begin
        if (run)
        begin
            case (ctrl.op)
                OP_MUL_DIFF: diff_reg <= mul_p[DIFF_W-1:0];
                OP_MUL_LO:   prod_reg <= PROD_W'(mul_p);
                OP_MUL_HI:   mul_reg  <= mul_p;
                OP_ADD_HI:   prod_reg <= prod_reg + (PROD_W'(mul_reg) <<< HALF_W);
                default:     ;
            endcase
        end
    end

    // Energy decision and table lookup
    logic [PROD_W-1:0]  idx_full;
    logic               over_range;
    logic [IDX_W-1:0]   rom_addr;
    logic               nonpos_reg;
    logic               over_reg;
    logic [ENTRY_W-1:0] rom_q_reg;

    assign idx_full   = unsigned'(prod_reg) >> SHIFT;
    assign over_range = idx_full >= PROD_W'(TABLE_DEPTH);
    assign rom_addr   = over_range ? '0 : idx_full[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (run && ctrl.op == OP_DECIDE)
        begin
            nonpos_reg <= prod_reg[PROD_W-1] || (prod_reg == '0);
            over_reg   <= over_range;
            rom_q_reg  <= EXP_ROM[rom_addr];
        end
    end

    // Finish: update the chain and load the output register
    logic                    take;
    logic signed [POS_W-1:0] sample_reg;
    logic                    accepted_reg;

    assign take = nonpos_reg || (!over_reg && ({1'b0, draw_reg} < rom_q_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (run && ctrl.op == OP_FINISH)
            begin
                position_reg     <= take ? cand_reg : base_reg;
                result_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (run && ctrl.op == OP_FINISH)
        begin
            sample_reg   <= take ? cand_reg : base_reg;
            accepted_reg <= take;
        end
    end

    assign result.valid    = result_valid_reg;
    assign result.sample   = sample_reg;
    assign result.accepted = accepted_reg;

endmodule
